/* rtl/bli_pkg.sv */
// ----------------------------------------------------------------------------
// bli_pkg
// shared types and constants of the breakpoint lookup interpolator
// ----------------------------------------------------------------------------
package bli_pkg;

  // default store sizes
  localparam int BLI_BREAKPOINTS = 64;
  localparam int BLI_COLUMNS     = 4;

  // most results one lookup can produce
  localparam int BLI_MAX_OUT = 4;

  // configuration port
  localparam int BLI_CFG_IDX_W  = 1;
  localparam int BLI_CFG_DATA_W = 7;

  typedef enum logic [BLI_CFG_IDX_W-1:0] {
    REG_BREAKPOINTS_IN_USE = 1'd0,
    REG_COLUMNS_IN_USE     = 1'd1
  } bli_cfg_reg_t;

  // request operations
  typedef enum logic [1:0] {
    OP_LOOKUP     = 2'd0,
    OP_WRITE_BP   = 2'd1,
    OP_WRITE_DATA = 2'd2
  } bli_op_t;

  // end clamp codes
  typedef enum logic [1:0] {
    CLAMP_NONE  = 2'd0,
    CLAMP_FIRST = 2'd1,
    CLAMP_LAST  = 2'd2
  } bli_clamp_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic [5:0]         entry_index;
    logic [1:0]         column_index;
    logic signed [31:0] operand_value;
  } bli_req_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         result_column;
    logic [1:0]         end_clamp;
    logic               last_of_run;
  } bli_rsp_t;

endpackage

/* rtl/bli_ram.sv */
// ----------------------------------------------------------------------------
// bli_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module bli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/bli_muldiv.sv */
// ----------------------------------------------------------------------------
// bli_muldiv
// unsigned floor(mag * num / den), two partial products then restoring divide
// ----------------------------------------------------------------------------
module bli_muldiv (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] mag,
  input  logic [31:0] den,
  output logic        done,
  output logic [31:0] quot
);

  typedef enum logic [2:0] {
    M_IDLE,
    M_LO,
    M_HI,
    M_ADD,
    M_DIV
  } md_state_t;

  md_state_t   state;
  logic [31:0] num_r;
  logic [31:0] mag_r;
  logic [31:0] den_r;
  logic [63:0] acc;
  logic [47:0] prod;
  logic [31:0] rem;
  logic [31:0] low;
  logic [4:0]  cnt;

  logic [47:0] part_lo;
  logic [47:0] part_hi;
  logic [63:0] sum;
  logic [32:0] trial;
  logic        take;

  always_comb begin
    part_lo = num_r * mag_r[15:0];
    part_hi = num_r * mag_r[31:16];
    sum     = acc + {prod, 16'b0};
    trial   = {rem, low[31]};
    take    = trial >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      // pulses the cycle after the last divide step
      done <= (state == M_DIV) && (cnt == 5'd0);
      unique case (state)
        M_IDLE: begin
          if (start) begin
            num_r <= num;
            mag_r <= mag;
            den_r <= den;
            state <= M_LO;
          end
        end
        M_LO: begin
          acc   <= {16'b0, part_lo};
          state <= M_HI;
        end
        M_HI: begin
          prod  <= part_hi;
          state <= M_ADD;
        end
        M_ADD: begin
          // quotient fits 32 bits, so the upper half is already below den
          rem   <= sum[63:32];
          low   <= sum[31:0];
          cnt   <= 5'd31;
          state <= M_DIV;
        end
        M_DIV: begin
          rem  <= take ? 32'(trial - {1'b0, den_r}) : trial[31:0];
          low  <= {low[30:0], 1'b0};
          quot <= {quot[30:0], take};
          if (cnt == 5'd0) begin
            state <= M_IDLE;
          end else begin
            cnt <= cnt - 5'd1;
          end
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

/* rtl/breakpoint_lookup_interpolator_unit.sv */
// ----------------------------------------------------------------------------
// breakpoint_lookup_interpolator_unit
// 1-d breakpoint table lookup with linear interpolation, q16.16
// ----------------------------------------------------------------------------
// usage
//   req channel (req_valid/req_ready/req): one request is a lookup, a
//   breakpoint write or a table data write. writes take effect in the cycle
//   they are accepted and the block is ready again on the next cycle.
//   rsp channel (rsp_valid/rsp_ready/rsp): a lookup returns one response per
//   column in use, in column order, the final one with last_of_run set.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready, to be
//   used only while no lookup is in flight; the block does not enforce this.
// sequence
//   a lookup first reads both end breakpoints; a target between them adds a
//   binary search (at most ceil(log2(n - 1)) steps for n breakpoints in
//   use). each column is then read from the table and either emitted when
//   clamped or interpolated in the shared multiply/divide unit (two 32x16
//   partial products and a 32 step restoring divide). one request is worked
//   at a time.
// reset
//   synchronous, clears the controller and the output register; registers
//   return to one breakpoint and one column. stores are not cleared.
// stalls
//   a response waits in the output register while rsp_ready is low; the block
//   holds in its emit step until the register frees.
// ----------------------------------------------------------------------------
module breakpoint_lookup_interpolator_unit
  import bli_pkg::*;
#(
  parameter int BREAKPOINTS = BLI_BREAKPOINTS,
  parameter int COLUMNS     = BLI_COLUMNS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_ready,
  input  bli_req_t                  req,
  output logic                      rsp_valid,
  input  logic                      rsp_ready,
  output bli_rsp_t                  rsp,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [BLI_CFG_IDX_W-1:0]  cfg_index,
  input  logic [BLI_CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W     = $clog2(BREAKPOINTS);
  localparam int TBL_DEPTH = BREAKPOINTS * COLUMNS;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);
  localparam int COL_CAP   = (COLUMNS < BLI_MAX_OUT) ? COLUMNS : BLI_MAX_OUT;
  localparam int COL_W     = $clog2(BLI_MAX_OUT);

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_FIRST,
    S_RD_LAST,
    S_SEARCH,
    S_SEARCH_CMP,
    S_COL_RD1,
    S_COL_RD2,
    S_COL_D2,
    S_MULDIV,
    S_FINISH,
    S_EMIT
  } state_t;

  state_t state;

  // configuration registers, unsaturated as written (column count keeps cfg_data[2:0])
  logic [6:0] bp_count;
  logic [2:0] col_count;

  // lookup context
  logic signed [31:0] t_val;
  logic [IDX_W-1:0]   last_idx;
  logic [COL_W-1:0]   last_col;
  logic [IDX_W-1:0]   lo;
  logic [IDX_W-1:0]   hi;
  logic [IDX_W-1:0]   mid_r;
  logic signed [31:0] b_first;
  logic signed [31:0] r1;
  logic signed [31:0] r2;
  logic [31:0]        num;
  logic [31:0]        den;
  bli_clamp_t         clamp;
  logic [COL_W-1:0]   col;
  logic signed [31:0] d1;
  logic               neg;
  logic [31:0]        q;
  logic signed [31:0] value;

  // memory ports
  logic              bp_we;
  logic [IDX_W-1:0]  bp_waddr;
  logic [IDX_W-1:0]  bp_raddr;
  logic [31:0]       bp_rdata;
  logic              tbl_we;
  logic [TBL_AW-1:0] tbl_waddr;
  logic [TBL_AW-1:0] tbl_raddr;
  logic [31:0]       tbl_rdata;

  // combinational helpers
  logic [IDX_W-1:0]  last_idx_sat;
  logic [COL_W-1:0]  last_col_sat;
  logic [IDX_W-1:0]  mid;
  logic [TBL_AW-1:0] lo_addr;
  logic [TBL_AW-1:0] hi_addr;
  logic [32:0]       diff;
  logic [31:0]       mag;
  logic              req_fire;
  logic              rsp_load;
  logic              md_start;
  logic              md_done;
  logic [31:0]       md_quot;

  assign req_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign req_fire  = req_valid && req_ready;
  assign rsp_load  = (state == S_EMIT) && (!rsp_valid || rsp_ready);
  assign md_start  = (state == S_COL_D2);

  // saturate the registers into their legal ranges
  always_comb begin
    if (bp_count == 7'd0) begin
      last_idx_sat = '0;
    end else if (32'(bp_count) > 32'(BREAKPOINTS)) begin
      last_idx_sat = IDX_W'(BREAKPOINTS - 1);
    end else begin
      last_idx_sat = IDX_W'(32'(bp_count) - 32'd1);
    end
    if (col_count == 3'd0) begin
      last_col_sat = '0;
    end else if (32'(col_count) > 32'(COL_CAP)) begin
      last_col_sat = COL_W'(COL_CAP - 1);
    end else begin
      last_col_sat = COL_W'(32'(col_count) - 32'd1);
    end
  end

  // write side of both stores, out-of-range writes dropped
  always_comb begin
    bp_waddr  = IDX_W'(req.entry_index);
    tbl_waddr = TBL_AW'(32'(req.entry_index) * 32'(COLUMNS) + 32'(req.column_index));
    bp_we     = req_fire && (req.operation == OP_WRITE_BP)
                && (32'(req.entry_index) < 32'(BREAKPOINTS));
    tbl_we    = req_fire && (req.operation == OP_WRITE_DATA)
                && (32'(req.entry_index) < 32'(BREAKPOINTS))
                && (32'(req.column_index) < 32'(COLUMNS));
  end

  // read addresses, issued in the state before the one that uses the data
  always_comb begin
    mid     = IDX_W'(({1'b0, lo} + {1'b0, hi}) >> 1);
    lo_addr = TBL_AW'(32'(lo) * 32'(COLUMNS) + 32'(col));
    hi_addr = TBL_AW'(32'(hi) * 32'(COLUMNS) + 32'(col));
    if (state == S_RD_FIRST) begin
      bp_raddr = last_idx;
    end else if (state == S_SEARCH) begin
      bp_raddr = mid;
    end else begin
      bp_raddr = '0;
    end
    tbl_raddr = (state == S_COL_RD1) ? lo_addr : hi_addr;
  end

  // slope sign and magnitude of d2 - d1
  always_comb begin
    diff = {tbl_rdata[31], tbl_rdata} - {d1[31], d1};
    mag  = diff[32] ? 32'(~diff + 33'd1) : diff[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      bp_count  <= 7'd1;
      col_count <= 3'd1;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_BREAKPOINTS_IN_USE: bp_count  <= cfg_data;
          REG_COLUMNS_IN_USE:     col_count <= cfg_data[2:0];
        endcase
      end

      // a new load in the same cycle keeps the register full
      if (rsp_valid && rsp_ready && !rsp_load) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          // writes complete here; only a lookup leaves idle
          if (req_fire && req.operation == OP_LOOKUP) begin
            t_val    <= req.operand_value;
            last_idx <= last_idx_sat;
            last_col <= last_col_sat;
            state    <= S_RD_FIRST;
          end
        end
        S_RD_FIRST: begin
          b_first <= bp_rdata;
          state   <= S_RD_LAST;
        end
        S_RD_LAST: begin
          col <= '0;
          if (t_val <= b_first) begin
            clamp <= CLAMP_FIRST;
            lo    <= '0;
            state <= S_COL_RD1;
          end else if (t_val >= $signed(bp_rdata)) begin
            clamp <= CLAMP_LAST;
            lo    <= last_idx;
            state <= S_COL_RD1;
          end else begin
            clamp <= CLAMP_NONE;
            lo    <= '0;
            hi    <= last_idx;
            r1    <= b_first;
            r2    <= bp_rdata;
            state <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          // bracket holds r1 <= t < r2; narrow until the entries are adjacent
          if (({1'b0, lo} + 1'b1) < {1'b0, hi}) begin
            mid_r <= mid;
            state <= S_SEARCH_CMP;
          end else begin
            num   <= 32'(t_val - r1);
            den   <= 32'(r2 - r1);
            state <= S_COL_RD1;
          end
        end
        S_SEARCH_CMP: begin
          if ($signed(bp_rdata) <= t_val) begin
            lo <= mid_r;
            r1 <= bp_rdata;
          end else begin
            hi <= mid_r;
            r2 <= bp_rdata;
          end
          state <= S_SEARCH;
        end
        S_COL_RD1: begin
          state <= S_COL_RD2;
        end
        S_COL_RD2: begin
          d1 <= tbl_rdata;
          if (clamp != CLAMP_NONE) begin
            value <= tbl_rdata;
            state <= S_EMIT;
          end else begin
            state <= S_COL_D2;
          end
        end
        S_COL_D2: begin
          neg   <= diff[32];
          state <= S_MULDIV;
        end
        S_MULDIV: begin
          if (md_done) begin
            q     <= md_quot;
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          value <= neg ? (d1 - $signed(q)) : (d1 + $signed(q));
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (rsp_load) begin
            rsp_valid         <= 1'b1;
            rsp.result_value  <= value;
            rsp.result_column <= col;
            rsp.end_clamp     <= clamp;
            rsp.last_of_run   <= (col == last_col);
            if (col == last_col) begin
              state <= S_IDLE;
            end else begin
              col   <= col + 1'b1;
              state <= S_COL_RD1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  bli_ram #(
    .WIDTH (32),
    .DEPTH (BREAKPOINTS)
  ) u_bp_ram (
    .clk   (clk),
    .we    (bp_we),
    .waddr (bp_waddr),
    .wdata (req.operand_value),
    .raddr (bp_raddr),
    .rdata (bp_rdata)
  );

  bli_ram #(
    .WIDTH (32),
    .DEPTH (TBL_DEPTH)
  ) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (req.operand_value),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  bli_muldiv u_muldiv (
    .clk   (clk),
    .rst   (rst),
    .start (md_start),
    .num   (num),
    .mag   (mag),
    .den   (den),
    .done  (md_done),
    .quot  (md_quot)
  );

`ifndef NO_ASSERTIONS
  a_lookup_starts: assert property (@(posedge clk) disable iff (rst)
    (req_fire && req.operation == OP_LOOKUP) |=> state == S_RD_FIRST)
    else $error("lookup request did not start the breakpoint reads");

  a_search_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) |-> lo < hi)
    else $error("search bracket collapsed");

  a_search_bracket: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) |-> (r1 <= t_val && t_val < r2))
    else $error("target left the search bracket");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    md_done |-> state == S_MULDIV)
    else $error("divide finished outside its wait step");
`endif

endmodule
